/* src/dsar_pkg.sv */
// ----------------------------------------------------------------------------
// dsar_pkg
// Shared types, widths and constants of the drop-shadow alpha ramp unit.
// ----------------------------------------------------------------------------
package dsar_pkg;

    localparam int COORD_W  = 13;
    localparam int DIM_W    = 12;
    localparam int SHADOW_W = 8;
    localparam int NUM_W    = 15;
    localparam int ALPHA_W  = 7;
    localparam int IDX_W    = 2;

    localparam logic [DIM_W-1:0]    MAX_CONTENT_DIM = 12'd4095;
    localparam logic [SHADOW_W-1:0] MAX_SHADOW      = 8'd255;
    localparam logic [ALPHA_W-1:0]  PEAK_ALPHA      = 7'd92;

    // geometry stages, divider steps, output register
    localparam int DIV_STEPS  = ALPHA_W;
    localparam int PIPE_DEPTH = 3 + DIV_STEPS + 1;

    typedef logic [COORD_W-1:0]  t_coord;
    typedef logic [DIM_W-1:0]    t_dim;
    typedef logic [SHADOW_W-1:0] t_shadow;
    typedef logic [NUM_W-1:0]    t_num;
    typedef logic [ALPHA_W-1:0]  t_alpha;
    typedef logic [IDX_W-1:0]    t_reg_idx;

    localparam t_reg_idx REG_CONTENT_WIDTH  = 2'd0;
    localparam t_reg_idx REG_CONTENT_HEIGHT = 2'd1;
    localparam t_reg_idx REG_SHADOW_SIZE    = 2'd2;

    typedef struct packed {
        t_dim    content_width;
        t_dim    content_height;
        t_shadow shadow_size;
    } t_cfg;

    // per-pixel classification that rides along with the ramp value
    typedef struct packed {
        logic outside;
        logic in_rect;
        logic ring;
    } t_flags;

endpackage

/* src/dsar_geom.sv */
// ----------------------------------------------------------------------------
// dsar_geom
// Three-stage geometry front end: axis distances, Chebyshev distance and
// classification, then the scaled ramp numerator 92*(shadow_size-d).
// ----------------------------------------------------------------------------
module dsar_geom (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  dsar_pkg::t_coord i_pixel_x,
    input  dsar_pkg::t_coord i_pixel_y,
    input  dsar_pkg::t_cfg  i_cfg,
    output logic            o_valid,
    output dsar_pkg::t_num  o_num,
    output dsar_pkg::t_flags o_flags
);
    import dsar_pkg::*;

    // stage a: distances per axis
    logic               r_a_valid;
    logic               r_a_outside;
    t_coord             r_a_dx;
    t_coord             r_a_dy;
    logic               n_a_outside;
    t_coord             n_a_dx;
    t_coord             n_a_dy;
    t_coord             s_ext;
    t_coord             right_x;
    t_coord             bottom_y;
    logic [COORD_W:0]   buf_w;
    logic [COORD_W:0]   buf_h;

    // stage b: classification
    logic               r_b_valid;
    t_flags             r_b_flags;
    t_shadow            r_b_diff;
    t_flags             n_b_flags;
    t_shadow            n_b_diff;
    t_coord             d;

    // stage c: numerator
    logic               r_c_valid;
    t_flags             r_c_flags;
    t_num               r_c_num;

    always_comb begin
        s_ext    = t_coord'(i_cfg.shadow_size);
        right_x  = s_ext + t_coord'(i_cfg.content_width);
        bottom_y = s_ext + t_coord'(i_cfg.content_height);
        buf_w    = {1'b0, right_x} + (COORD_W+1)'(i_cfg.shadow_size);
        buf_h    = {1'b0, bottom_y} + (COORD_W+1)'(i_cfg.shadow_size);
        n_a_outside = ({1'b0, i_pixel_x} >= buf_w) || ({1'b0, i_pixel_y} >= buf_h);

        if (i_pixel_x < s_ext) begin
            n_a_dx = s_ext - i_pixel_x;
        end else if (i_pixel_x >= right_x) begin
            n_a_dx = i_pixel_x - right_x + t_coord'(1);
        end else begin
            n_a_dx = '0;
        end

        if (i_pixel_y < s_ext) begin
            n_a_dy = s_ext - i_pixel_y;
        end else if (i_pixel_y >= bottom_y) begin
            n_a_dy = i_pixel_y - bottom_y + t_coord'(1);
        end else begin
            n_a_dy = '0;
        end
    end

    always_comb begin
        d = (r_a_dx > r_a_dy) ? r_a_dx : r_a_dy;
        n_b_flags.outside = r_a_outside;
        n_b_flags.in_rect = !r_a_outside && (d == '0);
        // zero shadow size never passes the compare, so no ring
        n_b_flags.ring    = !r_a_outside && (d != '0)
                            && (d < t_coord'(i_cfg.shadow_size));
        n_b_diff = n_b_flags.ring ? (i_cfg.shadow_size - d[SHADOW_W-1:0]) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_outside <= n_a_outside;
        r_a_dx      <= n_a_dx;
        r_a_dy      <= n_a_dy;
        r_b_flags   <= n_b_flags;
        r_b_diff    <= n_b_diff;
        r_c_flags   <= r_b_flags;
        r_c_num     <= t_num'(r_b_diff) * t_num'(PEAK_ALPHA);
    end

    assign o_valid = r_c_valid;
    assign o_num   = r_c_num;
    assign o_flags = r_c_flags;

    a_class_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> !(r_b_flags.ring && r_b_flags.in_rect)
                      && !(r_b_flags.outside && (r_b_flags.ring || r_b_flags.in_rect)))
        else $error("geometry flags overlap");

    a_diff_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && r_b_flags.ring |-> (r_b_diff != '0) && (r_b_diff < i_cfg.shadow_size))
        else $error("ramp difference out of range");

    a_num_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_valid && !r_c_flags.ring |-> (r_c_num == '0))
        else $error("nonzero numerator off the ring");

endmodule

/* src/dsar_div.sv */
// ----------------------------------------------------------------------------
// dsar_div
// Pipelined restoring divider, one quotient bit per stage, dividing the
// ramp numerator by shadow_size. Flags travel alongside the partial result.
// ----------------------------------------------------------------------------
module dsar_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  dsar_pkg::t_num   i_num,
    input  dsar_pkg::t_flags i_flags,
    input  dsar_pkg::t_shadow i_divisor,
    output logic             o_valid,
    output dsar_pkg::t_alpha o_quot,
    output dsar_pkg::t_flags o_flags
);
    import dsar_pkg::*;

    logic   r_vld   [DIV_STEPS];
    t_num   r_rem   [DIV_STEPS];
    t_alpha r_quot  [DIV_STEPS];
    t_flags r_flags [DIV_STEPS];

    genvar k;
    generate
        for (k = 0; k < DIV_STEPS; k++) begin : g_step
            localparam int BIT = DIV_STEPS - 1 - k;
            logic   in_vld;
            t_num   in_rem;
            t_alpha in_quot;
            t_flags in_flags;
            t_num   trial;
            logic   take;

            if (k == 0) begin : g_first
                assign in_vld   = i_valid;
                assign in_rem   = i_num;
                assign in_quot  = '0;
                assign in_flags = i_flags;
            end else begin : g_next
                assign in_vld   = r_vld[k-1];
                assign in_rem   = r_rem[k-1];
                assign in_quot  = r_quot[k-1];
                assign in_flags = r_flags[k-1];
            end

            // quotient stays below 128, so the shifted divisor never overflows
            assign trial = t_num'(i_divisor) << BIT;
            assign take  = in_rem >= trial;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else begin
                    r_vld[k] <= in_vld;
                end
            end

            always_ff @(posedge i_clk) begin
                r_flags[k] <= in_flags;
                r_rem[k]   <= take ? (in_rem - trial) : in_rem;
                r_quot[k]  <= in_quot | (t_alpha'(take) << BIT);
            end
        end
    endgenerate

    assign o_valid = r_vld[DIV_STEPS-1];
    assign o_quot  = r_quot[DIV_STEPS-1];
    assign o_flags = r_flags[DIV_STEPS-1];

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[DIV_STEPS-1] && r_flags[DIV_STEPS-1].ring
        |-> (r_rem[DIV_STEPS-1] < t_num'(i_divisor)))
        else $error("divider remainder not below divisor");

    a_quot_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[DIV_STEPS-1] && r_flags[DIV_STEPS-1].ring
        |-> (r_quot[DIV_STEPS-1] < PEAK_ALPHA))
        else $error("ring alpha reached peak");

    a_valid_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |=> r_vld[0])
        else $error("valid lost entering divider");

endmodule

/* src/drop_shadow_alpha_ramp_unit.sv */
// ----------------------------------------------------------------------------
// drop_shadow_alpha_ramp_unit
// Shadow alpha for one pixel coordinate of a drop-shadow buffer.
// ----------------------------------------------------------------------------
// Takes one pixel word per clock: busy is never raised, so start may be held
// high every cycle of a raster scan. Each word gives one result word, shown for
// one cycle with o_valid; the receiver cannot stall it. The pipeline holds three
// geometry stages, seven divider stages (one quotient bit each) and the output
// register. Configuration registers are written through the cfg channel, which
// is always ready, and must only change while no pixel word is in flight.
module drop_shadow_alpha_ramp_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  dsar_pkg::t_coord    i_pixel_x,
    input  dsar_pkg::t_coord    i_pixel_y,
    output logic                o_valid,
    output dsar_pkg::t_alpha    o_alpha,
    output logic                o_outside_buffer,
    output logic                o_in_content,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  dsar_pkg::t_reg_idx  i_cfg_index,
    input  dsar_pkg::t_dim      i_cfg_data
);
    import dsar_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    logic     geo_valid;
    t_num     geo_num;
    t_flags   geo_flags;
    logic     div_valid;
    t_alpha   div_quot;
    t_flags   div_flags;
    logic     r_valid;
    t_alpha   r_alpha;
    logic     r_outside;
    logic     r_inside;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_CONTENT_WIDTH: begin
                    n_cfg.content_width = (i_cfg_data > MAX_CONTENT_DIM) ?
                                          MAX_CONTENT_DIM : i_cfg_data;
                end
                REG_CONTENT_HEIGHT: begin
                    n_cfg.content_height = (i_cfg_data > MAX_CONTENT_DIM) ?
                                           MAX_CONTENT_DIM : i_cfg_data;
                end
                REG_SHADOW_SIZE: begin
                    n_cfg.shadow_size = (i_cfg_data[SHADOW_W-1:0] > MAX_SHADOW) ?
                                        MAX_SHADOW : i_cfg_data[SHADOW_W-1:0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.content_width  <= t_dim'(1);
            r_cfg.content_height <= t_dim'(1);
            r_cfg.shadow_size    <= t_shadow'(1);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    dsar_geom u_geom (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (start && !busy),
        .i_pixel_x (i_pixel_x),
        .i_pixel_y (i_pixel_y),
        .i_cfg     (r_cfg),
        .o_valid   (geo_valid),
        .o_num     (geo_num),
        .o_flags   (geo_flags)
    );

    dsar_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (geo_valid),
        .i_num     (geo_num),
        .i_flags   (geo_flags),
        .i_divisor (r_cfg.shadow_size),
        .o_valid   (div_valid),
        .o_quot    (div_quot),
        .o_flags   (div_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= div_valid;
        end
    end

    // off the ring the divider output is meaningless, force alpha to zero
    always_ff @(posedge i_clk) begin
        r_alpha   <= div_flags.ring ? div_quot : '0;
        r_outside <= div_flags.outside;
        r_inside  <= div_flags.in_rect;
    end

    assign o_valid          = r_valid;
    assign o_alpha          = r_alpha;
    assign o_outside_buffer = r_outside;
    assign o_in_content     = r_inside;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##PIPE_DEPTH o_valid)
        else $error("result word missing after pipeline latency");

    a_outside_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_outside_buffer |-> (o_alpha == '0) && !o_in_content)
        else $error("outside pixel carries alpha or content flag");

    a_content_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_in_content |-> (o_alpha == '0))
        else $error("content pixel carries alpha");

endmodule

/* bench/drop_shadow_alpha_ramp_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// drop_shadow_alpha_ramp_unit_tb
// Self-checking bench for the drop-shadow alpha ramp unit. A short directed
// table walks the reset geometry, the largest buffer, an empty content area
// and a zero-width ring. Random geometries and pixel words follow, first with
// a sender that idles now and then, then a sluggish one, then back to back.
// Every result word is compared with a local ramp calculation.
// ----------------------------------------------------------------------------
module drop_shadow_alpha_ramp_unit_tb;
    import dsar_pkg::*;

    localparam int       ITEMS_PER_SETTING  = 60;
    localparam int       SETTINGS_PER_PHASE = 8;
    localparam int       STALL_LIMIT        = 2000;
    localparam t_reg_idx REG_UNUSED         = 2'd3;

    typedef struct packed {
        t_alpha alpha;
        logic   outside;
        logic   in_rect;
    } t_shade;

    typedef struct packed {
        logic   new_cfg;
        logic   poke;
        t_dim   w;
        t_dim   h;
        t_dim   sdata;
        t_coord x;
        t_coord y;
        logic   fixed;
        t_shade want;
    } t_row;

    localparam t_shade NO_SHADE = '0;

    logic     i_clk = 1'b0;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_coord   i_pixel_x;
    t_coord   i_pixel_y;
    logic     o_valid;
    t_alpha   o_alpha;
    logic     o_outside_buffer;
    logic     o_in_content;
    logic     i_cfg_valid;
    logic     o_cfg_ready;
    t_reg_idx i_cfg_index;
    t_dim     i_cfg_data;

    // typed expectation that travels with a directed pixel word
    logic     row_fixed;
    t_shade   row_want;

    // local copy of the geometry registers
    t_dim     m_width  = 12'd1;
    t_dim     m_height = 12'd1;
    t_shadow  m_shadow = 8'd1;

    t_shade   shade_due[$];
    t_row     dir_rows[$];

    int errors    = 0;
    int n_pixels  = 0;
    int n_results = 0;
    int n_cfg     = 0;
    int n_ring    = 0;
    int n_inside  = 0;
    int n_outside = 0;
    int n_clear   = 0;
    int idle_run  = 0;
    int gap_pct   = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    drop_shadow_alpha_ramp_unit i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_pixel_x        (i_pixel_x),
        .i_pixel_y        (i_pixel_y),
        .o_valid          (o_valid),
        .o_alpha          (o_alpha),
        .o_outside_buffer (o_outside_buffer),
        .o_in_content     (o_in_content),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    function automatic t_shade shade(int a, logic o, logic i);
        return {t_alpha'(a), o, i};
    endfunction

    // distance along one axis from coordinate c to the span [s, lim)
    function automatic int unsigned axis_gap(int unsigned c, int unsigned s, int unsigned lim);
        if (c < s)
            return s - c;
        if (c >= lim)
            return c - lim + 1;
        return 0;
    endfunction

    function automatic t_shade shade_pixel(t_coord x, t_coord y);
        int unsigned s;
        int unsigned right;
        int unsigned bottom;
        int unsigned dx;
        int unsigned dy;
        int unsigned d;
        t_shade      r;
        s      = m_shadow;
        right  = s + m_width;
        bottom = s + m_height;
        r      = NO_SHADE;
        if (x >= right + s || y >= bottom + s) begin
            r.outside = 1'b1;
        end else begin
            dx = axis_gap(x, s, right);
            dy = axis_gap(y, s, bottom);
            d  = (dx > dy) ? dx : dy;
            if (d == 0)
                r.in_rect = 1'b1;
            else if (d < s)
                r.alpha = t_alpha'((PEAK_ALPHA * (s - d)) / s);
        end
        return r;
    endfunction

    function automatic void add_row(logic new_cfg, logic poke, int w, int h, int sdata,
                                    int x, int y, logic fixed, t_shade want);
        t_row r;
        r.new_cfg = new_cfg;
        r.poke    = poke;
        r.w       = t_dim'(w);
        r.h       = t_dim'(h);
        r.sdata   = t_dim'(sdata);
        r.x       = t_coord'(x);
        r.y       = t_coord'(y);
        r.fixed   = fixed;
        r.want    = want;
        dir_rows.push_back(r);
    endfunction

    // mostly inside the buffer, some on its far edge, a few anywhere
    function automatic t_coord pick_coord(int bound);
        int r;
        r = $urandom_range(0, 19);
        if (r < 15 && bound > 0)
            return t_coord'($urandom_range(0, bound - 1));
        if (r < 18)
            return t_coord'(bound + $urandom_range(0, 2) - 1);
        return t_coord'($urandom);
    endfunction

    always @(posedge i_clk) begin : monitor
        t_shade got;
        t_shade want;
        if (!i_rst_n) begin
            m_width  = 12'd1;
            m_height = 12'd1;
            m_shadow = 8'd1;
        end else begin
            if (start && !busy) begin
                shade_due.push_back(row_fixed ? row_want : shade_pixel(i_pixel_x, i_pixel_y));
                n_pixels++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                n_cfg++;
                case (i_cfg_index)
                    REG_CONTENT_WIDTH: begin
                        m_width = (i_cfg_data > MAX_CONTENT_DIM) ? MAX_CONTENT_DIM : i_cfg_data;
                    end
                    REG_CONTENT_HEIGHT: begin
                        m_height = (i_cfg_data > MAX_CONTENT_DIM) ? MAX_CONTENT_DIM : i_cfg_data;
                    end
                    REG_SHADOW_SIZE: begin
                        m_shadow = (i_cfg_data[SHADOW_W-1:0] > MAX_SHADOW) ?
                                   MAX_SHADOW : i_cfg_data[SHADOW_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (o_valid) begin
                got = {o_alpha, o_outside_buffer, o_in_content};
                n_results++;
                if (got.outside)
                    n_outside++;
                else if (got.in_rect)
                    n_inside++;
                else if (got.alpha != 0)
                    n_ring++;
                else
                    n_clear++;
                if (shade_due.size() == 0) begin
                    $error("result word with nothing pending: alpha %0d", got.alpha);
                    errors++;
                end else begin
                    want = shade_due.pop_front();
                    if (got.alpha !== want.alpha) begin
                        $error("alpha: expected %0d, actual %0d", want.alpha, got.alpha);
                        errors++;
                    end
                    if (got.outside !== want.outside) begin
                        $error("outside_buffer: expected %0b, actual %0b",
                               want.outside, got.outside);
                        errors++;
                    end
                    if (got.in_rect !== want.in_rect) begin
                        $error("in_content: expected %0b, actual %0b",
                               want.in_rect, got.in_rect);
                        errors++;
                    end
                end
            end
        end
    end

    // ends the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready))
            idle_run = 0;
        else
            idle_run++;
        if (idle_run >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_pixel(t_coord x, t_coord y, logic fixed, t_shade want);
        start     <= 1'b1;
        i_pixel_x <= x;
        i_pixel_y <= y;
        row_fixed <= fixed;
        row_want  <= want;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // n must be at least one so start is never dropped and raised in one step
    task automatic hold_off(int n);
        start     <= 1'b0;
        i_pixel_x <= t_coord'($urandom);
        i_pixel_y <= t_coord'($urandom);
        repeat (n) @(posedge i_clk);
    endtask

    // wait until every pending word has come back
    task automatic drain();
        start <= 1'b0;
        do @(negedge i_clk); while (shade_due.size() != 0);
        @(posedge i_clk);
    endtask

    task automatic program_regs(t_dim w, t_dim h, t_dim sdata, logic poke);
        for (int k = 0; k < 4; k++) begin
            if (k == 3 && !poke)
                break;
            i_cfg_valid <= 1'b1;
            case (k)
                0: begin
                    i_cfg_index <= REG_CONTENT_WIDTH;
                    i_cfg_data  <= w;
                end
                1: begin
                    i_cfg_index <= REG_CONTENT_HEIGHT;
                    i_cfg_data  <= h;
                end
                2: begin
                    i_cfg_index <= REG_SHADOW_SIZE;
                    i_cfg_data  <= sdata;
                end
                default: begin
                    i_cfg_index <= REG_UNUSED;
                    i_cfg_data  <= t_dim'($urandom);
                end
            endcase
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : driver
        int   mode;
        int   w;
        int   h;
        int   s;
        t_dim sdata;
        int   bw;
        int   bh;

        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_pixel_x   <= '0;
        i_pixel_y   <= '0;
        row_fixed   <= 1'b0;
        row_want    <= NO_SHADE;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_CONTENT_WIDTH;
        i_cfg_data  <= '0;

        // reset geometry: 3x3 buffer, the centre pixel is the content
        add_row(0, 0, 0, 0, 0, 0, 0, 1, shade(0, 0, 0));
        add_row(0, 0, 0, 0, 0, 1, 1, 1, shade(0, 0, 1));
        add_row(0, 0, 0, 0, 0, 3, 1, 1, shade(0, 1, 0));
        add_row(0, 0, 0, 0, 0, 1, 3, 1, shade(0, 1, 0));
        add_row(0, 0, 0, 0, 0, 8191, 8191, 1, shade(0, 1, 0));
        // 4x3 content with a 10 pixel ring, plus a write to the spare index
        add_row(1, 1, 4, 3, 10, 0, 0, 0, NO_SHADE);
        add_row(0, 0, 0, 0, 0, 9, 10, 0, NO_SHADE);
        add_row(0, 0, 0, 0, 0, 5, 12, 0, NO_SHADE);
        add_row(0, 0, 0, 0, 0, 13, 12, 0, NO_SHADE);
        add_row(0, 0, 0, 0, 0, 14, 15, 0, NO_SHADE);
        add_row(0, 0, 0, 0, 0, 23, 22, 0, NO_SHADE);
        add_row(0, 0, 0, 0, 0, 24, 0, 1, shade(0, 1, 0));
        add_row(0, 0, 0, 0, 0, 0, 23, 1, shade(0, 1, 0));
        // no ring: the whole buffer is content
        add_row(1, 0, 5, 5, 0, 0, 0, 1, shade(0, 0, 1));
        add_row(0, 0, 0, 0, 0, 4, 4, 1, shade(0, 0, 1));
        add_row(0, 0, 0, 0, 0, 5, 2, 1, shade(0, 1, 0));
        // empty content area, the ring is still there
        add_row(1, 0, 0, 7, 3, 3, 3, 0, NO_SHADE);
        add_row(0, 0, 0, 0, 0, 2, 5, 0, NO_SHADE);
        add_row(0, 0, 0, 0, 0, 0, 0, 0, NO_SHADE);
        // largest buffer, shadow written with its upper data bits set
        add_row(1, 0, 4095, 4095, 12'hFFF, 4604, 4604, 0, NO_SHADE);
        add_row(0, 0, 0, 0, 0, 254, 254, 0, NO_SHADE);
        add_row(0, 0, 0, 0, 0, 255, 255, 1, shade(0, 0, 1));
        add_row(0, 0, 0, 0, 0, 4605, 0, 1, shade(0, 1, 0));
        add_row(0, 0, 0, 0, 0, 0, 4604, 0, NO_SHADE);
        add_row(0, 0, 0, 0, 0, 1, 2300, 0, NO_SHADE);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].new_cfg) begin
                drain();
                program_regs(dir_rows[i].w, dir_rows[i].h, dir_rows[i].sdata, dir_rows[i].poke);
            end
            send_pixel(dir_rows[i].x, dir_rows[i].y, dir_rows[i].fixed, dir_rows[i].want);
        end

        for (int p = 0; p < 3; p++) begin
            gap_pct = (p == 0) ? 15 : (p == 1) ? 82 : 0;
            for (int set = 0; set < SETTINGS_PER_PHASE; set++) begin
                mode = (p == 0 && set < 2) ? set : $urandom_range(0, 9);
                case (mode)
                    0: begin
                        w = 4095;
                        h = 4095;
                        s = 255;
                    end
                    1: begin
                        w = 1;
                        h = 1;
                        s = 1;
                    end
                    2: begin
                        w = $urandom_range(0, 20);
                        h = $urandom_range(0, 20);
                        s = 0;
                    end
                    3: begin
                        w = $urandom_range(0, 1) ? 0 : $urandom_range(1, 20);
                        h = (w != 0) ? 0 : $urandom_range(0, 20);
                        s = $urandom_range(1, 12);
                    end
                    4: begin
                        w = $urandom_range(0, 4095);
                        h = $urandom_range(0, 4095);
                        s = $urandom_range(0, 255);
                    end
                    default: begin
                        w = $urandom_range(1, 24);
                        h = $urandom_range(1, 24);
                        s = $urandom_range(1, 20);
                    end
                endcase
                // upper data bits of the shadow word are don't-care
                sdata = t_dim'(($urandom & 32'hF00) | s);
                bw    = w + 2 * s;
                bh    = h + 2 * s;
                drain();
                program_regs(t_dim'(w), t_dim'(h), sdata, $urandom_range(0, 3) == 0);
                for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
                    if (n == ITEMS_PER_SETTING / 2 && set == 0)
                        drain();
                    // each cycle is idle with the phase's odds
                    while ($urandom_range(0, 99) < gap_pct)
                        hold_off(1);
                    send_pixel(pick_coord(bw), pick_coord(bh), 1'b0, NO_SHADE);
                end
            end
        end

        drain();
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);

        $display("%0d pixel words, %0d result words, %0d register writes",
                 n_pixels, n_results, n_cfg);
        $display("ramp %0d, content %0d, beyond buffer %0d, transparent ring %0d",
                 n_ring, n_inside, n_outside, n_clear);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
